[rtl/serial_reply_frame_parser_unit_assert.svh]
// Assertion macros for the serial reply frame parser.
`ifndef SERIAL_REPLY_FRAME_PARSER_UNIT_ASSERT_SVH
`define SERIAL_REPLY_FRAME_PARSER_UNIT_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication, sampled on clk, off during reset.
`define SRFP_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("srfp: same-cycle check failed");
// Next-cycle implication, sampled on clk, off during reset.
`define SRFP_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("srfp: next-cycle check failed");
`else
`define SRFP_ASSERT_IMP(lbl, ante, cons)
`define SRFP_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

[rtl/srfp_pkg.sv]
// Shared types and constants of the serial reply frame parser.
package srfp_pkg;

	localparam logic [7:0] START_BYTE       = 8'h53;
	localparam logic [7:0] BODY_LIMIT       = 8'd250;
	localparam logic [7:0] RST_DEVICE_CLASS = 8'd7;
	localparam logic [7:0] RST_DEVICE_ID    = 8'd0;
	localparam logic [7:0] RST_REPLY_LENGTH = 8'd0;

	typedef enum logic [2:0] {
		PH_IDLE   = 3'd0,
		PH_HEADER = 3'd1,
		PH_BODY   = 3'd2,
		PH_CHECK  = 3'd3,
		PH_IGNORE = 3'd4
	} phase_t;

	typedef enum logic [1:0] {
		CFG_DEVICE_CLASS = 2'd0,
		CFG_DEVICE_ID    = 2'd1,
		CFG_REPLY_LENGTH = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic       op;
		logic [7:0] rx_byte;
	} in_item_t;

	typedef struct packed {
		logic       body_valid;
		logic [7:0] body_byte;
		logic [7:0] body_index;
		logic       answer_ready;
		logic       checksum_error;
		logic [2:0] phase;
	} result_t;

	typedef struct packed {
		logic [7:0] device_class;
		logic [7:0] device_id;
		logic [7:0] reply_length;
	} cfg_t;

endpackage

[rtl/srfp_cfg.sv]
// Configuration register file of the serial reply frame parser.
module srfp_cfg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	input  logic [1:0]          cfg_index,
	input  logic [7:0]          cfg_data,
	output srfp_pkg::cfg_t      cfg
);

	srfp_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.device_class <= srfp_pkg::RST_DEVICE_CLASS;
			cfg_q.device_id    <= srfp_pkg::RST_DEVICE_ID;
			cfg_q.reply_length <= srfp_pkg::RST_REPLY_LENGTH;
		end else if (cfg_valid) begin
			case (srfp_pkg::cfg_idx_t'(cfg_index))
				srfp_pkg::CFG_DEVICE_CLASS: cfg_q.device_class <= cfg_data;
				srfp_pkg::CFG_DEVICE_ID:    cfg_q.device_id    <= cfg_data;
				srfp_pkg::CFG_REPLY_LENGTH: cfg_q.reply_length <= cfg_data;
				default: ; // unmapped index: drop the write
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[rtl/srfp_core.sv]
// Frame state machine: parse state, next-state logic and per-item result.
module srfp_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 advance,
	input  srfp_pkg::in_item_t   item,
	input  srfp_pkg::cfg_t       cfg,
	output srfp_pkg::result_t    result
);

	typedef struct packed {
		srfp_pkg::phase_t phase;
		logic             header_step;
		logic [7:0]       body_count;
		logic [7:0]       running_sum;
		logic             ready_flag;
	} state_t;

	state_t state_q;
	state_t state_d;
	logic [7:0] count_inc;
	logic [7:0] sum_add;

	assign count_inc = state_q.body_count + 8'd1;
	assign sum_add   = state_q.running_sum + item.rx_byte;

	always_comb begin
		state_d = state_q;
		result  = '0;
		if (item.op) begin
			state_d = '{phase: srfp_pkg::PH_IDLE, header_step: 1'b0, body_count: 8'd0,
				running_sum: 8'd0, ready_flag: 1'b0};
		end else begin
			case (state_q.phase)
				srfp_pkg::PH_IDLE: begin
					if (item.rx_byte == srfp_pkg::START_BYTE) begin
						state_d.phase       = srfp_pkg::PH_HEADER;
						state_d.header_step = 1'b0;
						state_d.running_sum = srfp_pkg::START_BYTE;
					end
				end
				srfp_pkg::PH_HEADER: begin
					state_d.running_sum = sum_add;
					if (!state_q.header_step) begin
						if (item.rx_byte == cfg.device_class) begin
							state_d.header_step = 1'b1;
						end else begin
							state_d.phase = srfp_pkg::PH_IGNORE;
						end
					end else begin
						state_d.header_step = 1'b0;
						if (item.rx_byte != cfg.device_id) begin
							state_d.phase = srfp_pkg::PH_IGNORE;
						end else if (cfg.reply_length != 8'd0) begin
							state_d.phase      = srfp_pkg::PH_BODY;
							state_d.body_count = 8'd0;
						end else begin
							// header-only reply: good as soon as the id matches
							state_d.phase      = srfp_pkg::PH_IGNORE;
							state_d.ready_flag = 1'b1;
						end
					end
				end
				srfp_pkg::PH_BODY: begin
					state_d.running_sum = sum_add;
					if (state_q.body_count >= srfp_pkg::BODY_LIMIT) begin
						state_d.phase      = srfp_pkg::PH_IGNORE;
						state_d.body_count = 8'd0;
					end else begin
						result.body_valid  = 1'b1;
						result.body_byte   = item.rx_byte;
						result.body_index  = state_q.body_count;
						state_d.body_count = count_inc;
						if (count_inc == cfg.reply_length) begin
							state_d.phase = srfp_pkg::PH_CHECK;
						end
					end
				end
				srfp_pkg::PH_CHECK: begin
					if (state_q.running_sum != item.rx_byte) begin
						result.checksum_error = 1'b1;
					end else begin
						state_d.ready_flag = 1'b1;
					end
					state_d.phase = srfp_pkg::PH_IGNORE;
				end
				default: state_d.phase = srfp_pkg::PH_IGNORE;
			endcase
		end
		result.answer_ready = state_d.ready_flag;
		result.phase        = state_d.phase;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{phase: srfp_pkg::PH_IDLE, header_step: 1'b0, body_count: 8'd0,
				running_sum: 8'd0, ready_flag: 1'b0};
		end else if (advance) begin
			state_q <= state_d;
		end
	end

endmodule

[rtl/serial_reply_frame_parser_unit.sv]
// Serial reply frame parser: top level with input register and result register.
//
// Takes one received serial byte per item and tracks a reply frame of the form
// 'S', device class, device id, reply_length body bytes, then an 8-bit additive
// checksum over every earlier byte. Each item yields exactly one result: the body
// byte and its index when the byte belonged to the body, the sticky answer-ready
// flag, a one-item checksum error pulse and the phase after the byte. An item
// with op set starts a new exchange and clears all frame state and flags; the
// configuration registers are kept. A bad class or id, a bad checksum, a good
// checksum, a matching header-only reply or a body that runs past 250 bytes parks
// the parser in the ignoring phase until the next new-exchange item. Throughput
// is one item per clock while results are taken: the input register holds the
// item while the frame state update works on it, and the result register takes
// the outcome when the item advances. Input stalls only while both registers are
// full and the result is not taken. Write configuration only while no items are
// in flight. cfg_ready is always high; indexes 0, 1, 2 select device_class,
// device_id and reply_length, index 3 is dropped.
module serial_reply_frame_parser_unit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_ready,
	input  srfp_pkg::in_item_t   item_data,
	output logic                 result_valid,
	input  logic                 result_ready,
	output srfp_pkg::result_t    result_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [1:0]           cfg_index,
	input  logic [7:0]           cfg_data
);

	`include "serial_reply_frame_parser_unit_assert.svh"

	logic               item_valid_s1;
	srfp_pkg::in_item_t item_s1;
	logic               advance;
	logic               result_valid_q;
	srfp_pkg::result_t  result_q;
	srfp_pkg::result_t  core_result;
	srfp_pkg::cfg_t     cfg;

	// Advance the held item when the result register is empty or being drained.
	assign advance    = item_valid_s1 && (!result_valid_q || result_ready);
	// Take a new item whenever the input register is free or moving on.
	assign item_ready = !item_valid_s1 || advance;
	assign cfg_ready  = 1'b1;

	// Input register: hold the item until the state machine consumes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (item_ready) begin
			item_valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= item_data;
		end
	end

	srfp_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Frame state machine; its state moves only when an item advances.
	srfp_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (item_s1),
		.cfg     (cfg),
		.result  (core_result)
	);

	// Result register: load on advance, drop once the item is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= core_result;
		end
	end

	assign result_valid = result_valid_q;
	assign result_data  = result_q;

	// A body byte leaves the parser in the body or checksum phase.
	`SRFP_ASSERT_IMP(a_body_phase, result_valid && result_data.body_valid,
		(result_data.phase == srfp_pkg::PH_BODY) || (result_data.phase == srfp_pkg::PH_CHECK))
	// A checksum mismatch ends the frame without a good answer.
	`SRFP_ASSERT_IMP(a_cerr_ignore, result_valid && result_data.checksum_error,
		(result_data.phase == srfp_pkg::PH_IGNORE) && !result_data.answer_ready)
	// Body indexes stay below the body limit.
	`SRFP_ASSERT_IMP(a_index_range, result_valid && result_data.body_valid,
		result_data.body_index < srfp_pkg::BODY_LIMIT)
	// An empty result register never blocks input.
	`SRFP_ASSERT_IMP(a_no_stall, !result_valid_q, item_ready)
	// A new exchange always reports idle with the answer flag cleared.
	`SRFP_ASSERT_NXT(a_new_exch, advance && item_s1.op,
		(result_data.phase == srfp_pkg::PH_IDLE) && !result_data.answer_ready && result_valid)

endmodule

[tb/tb.sv]
// Self-checking testbench for the serial reply frame parser unit.
`timescale 1ns / 100ps

// Each item is predicted when it is accepted. The expected result goes into a queue, and
// a checking process compares every accepted result with the oldest entry, field by field.
// Directed tests come first: the reset settings, header mismatches, good and bad
// checksums, and long bodies. A pressure test follows, then random frames under four
// idling mixes. Registers are rewritten only once no result is outstanding.
module tb;
	import srfp_pkg::*;

	// Write to this index is dropped by the block
	localparam logic [1:0] CFG_UNUSED = 2'd3;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       item_valid = 1'b0;
	logic       item_ready;
	in_item_t   item_data = '0;
	logic       result_valid;
	logic       result_ready = 1'b0;
	result_t    result_data;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [7:0] cfg_data = '0;

	// Register copy and frame state of the predictor
	cfg_t       exp_cfg;
	phase_t     exp_phase;
	logic       exp_hdr_second;
	logic [7:0] exp_body_cnt;
	logic [7:0] exp_sum;
	logic       exp_ready;

	result_t     expected_results[$];
	int unsigned mismatches = 0;
	int unsigned useful_items = 0;
	int unsigned send_idle_pct = 0;
	int unsigned stall_pct = 0;
	int unsigned hold_req = 0;
	int unsigned hold_left = 0;

	serial_reply_frame_parser_unit DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item_data    (item_data),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result_data  (result_data),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Work out the result of one item and advance the frame state.
	// 'taken' is low when the parser merely drops the byte.
	function automatic result_t parse_reply_byte(input in_item_t it, output bit taken);
		result_t r;
		r = '0;
		taken = 1'b1;
		if (it.op) begin
			// New exchange: clear everything but the registers
			exp_phase = PH_IDLE;
			exp_hdr_second = 1'b0;
			exp_body_cnt = '0;
			exp_sum = '0;
			exp_ready = 1'b0;
		end else begin
			case (exp_phase)
				PH_IDLE: begin
					if (it.rx_byte == START_BYTE) begin
						exp_phase = PH_HEADER;
						exp_hdr_second = 1'b0;
						exp_sum = START_BYTE;
					end else
						taken = 1'b0;
				end
				PH_HEADER: begin
					exp_sum = exp_sum + it.rx_byte;
					if (!exp_hdr_second) begin
						if (it.rx_byte == exp_cfg.device_class)
							exp_hdr_second = 1'b1;
						else
							exp_phase = PH_IGNORE;
					end else begin
						exp_hdr_second = 1'b0;
						if (it.rx_byte != exp_cfg.device_id)
							exp_phase = PH_IGNORE;
						else if (exp_cfg.reply_length != 8'd0) begin
							exp_phase = PH_BODY;
							exp_body_cnt = '0;
						end else begin
							// Header-only reply is complete once the id matches
							exp_phase = PH_IGNORE;
							exp_ready = 1'b1;
						end
					end
				end
				PH_BODY: begin
					exp_sum = exp_sum + it.rx_byte;
					if (exp_body_cnt >= BODY_LIMIT) begin
						// Body has grown too long: drop the byte and give up
						exp_phase = PH_IGNORE;
						exp_body_cnt = '0;
					end else begin
						r.body_valid = 1'b1;
						r.body_byte = it.rx_byte;
						r.body_index = exp_body_cnt;
						exp_body_cnt = exp_body_cnt + 8'd1;
						if (exp_body_cnt == exp_cfg.reply_length)
							exp_phase = PH_CHECK;
					end
				end
				PH_CHECK: begin
					if (exp_sum != it.rx_byte)
						r.checksum_error = 1'b1;
					else
						exp_ready = 1'b1;
					exp_phase = PH_IGNORE;
				end
				default: begin
					exp_phase = PH_IGNORE;
					taken = 1'b0;
				end
			endcase
		end
		r.answer_ready = exp_ready;
		r.phase = exp_phase;
		return r;
	endfunction

	// Offer one item, hold it until accepted, then queue its expected result.
	// Valid is only lowered when an idle gap is drawn.
	task automatic send_byte(input logic op, input logic [7:0] b);
		in_item_t it;
		bit       taken;
		it.op = op;
		it.rx_byte = b;
		if ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		item_valid <= 1'b1;
		item_data <= it;
		do @(posedge clk); while (!item_ready);
		expected_results.push_back(parse_reply_byte(it, taken));
		if (taken)
			useful_items++;
	endtask

	// Any byte but the start byte
	function automatic logic [7:0] noise_byte();
		logic [7:0] b;
		do b = 8'($urandom_range(255)); while (b == START_BYTE);
		return b;
	endfunction

	// Send a whole frame with a random body; optionally spoil the checksum
	task automatic send_frame(input logic [7:0] cls, input logic [7:0] did,
			input int unsigned body_len, input bit bad_sum);
		logic [7:0] sum;
		logic [7:0] b;
		sum = START_BYTE + cls + did;
		send_byte(1'b0, START_BYTE);
		send_byte(1'b0, cls);
		send_byte(1'b0, did);
		repeat (body_len) begin
			b = 8'($urandom_range(255));
			sum = sum + b;
			send_byte(1'b0, b);
		end
		if (bad_sum)
			sum = sum + 8'($urandom_range(1, 255));
		send_byte(1'b0, sum);
	endtask

	// Drop valid and wait until every expected result has come back,
	// then allow for the pipeline to settle
	task automatic wait_idle();
		item_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Write one register; the caller lowers cfg_valid after the last write
	task automatic write_reg(input logic [1:0] idx, input logic [7:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_DEVICE_CLASS: exp_cfg.device_class = value;
			CFG_DEVICE_ID:    exp_cfg.device_id = value;
			CFG_REPLY_LENGTH: exp_cfg.reply_length = value;
			default: ;
		endcase
	endtask

	task automatic set_config(input logic [7:0] cls, input logic [7:0] did,
			input logic [7:0] len);
		write_reg(CFG_DEVICE_CLASS, cls);
		write_reg(CFG_DEVICE_ID, did);
		write_reg(CFG_REPLY_LENGTH, len);
		cfg_valid <= 1'b0;
	endtask

	// Reset settings: header-only replies with class 7 and id 0
	task automatic test_reset_settings();
		send_byte(1'b0, 8'h00);
		send_byte(1'b0, 8'hFF);
		send_frame(RST_DEVICE_CLASS, RST_DEVICE_ID, 0, 1'b0);
		send_byte(1'b0, START_BYTE);
		send_byte(1'b1, 8'hFF);
		send_byte(1'b0, START_BYTE);
		send_byte(1'b0, RST_DEVICE_CLASS);
		send_byte(1'b0, RST_DEVICE_ID);
		send_byte(1'b1, 8'h00);
	endtask

	// Wrong class, wrong id, and a write to the unused index that must change nothing
	task automatic test_header_mismatch();
		send_byte(1'b0, START_BYTE);
		send_byte(1'b0, 8'h06);
		send_byte(1'b0, START_BYTE);
		send_byte(1'b1, 8'h5A);
		send_byte(1'b0, START_BYTE);
		send_byte(1'b0, RST_DEVICE_CLASS);
		send_byte(1'b0, 8'h01);
		wait_idle();
		write_reg(CFG_UNUSED, 8'($urandom_range(255)));
		cfg_valid <= 1'b0;
		send_byte(1'b1, 8'h00);
		send_frame(RST_DEVICE_CLASS, RST_DEVICE_ID, 0, 1'b0);
	endtask

	task automatic test_checksum();
		wait_idle();
		set_config(8'hFF, 8'hFF, 8'd1);
		send_byte(1'b1, 8'h00);
		send_frame(8'hFF, 8'hFF, 1, 1'b0);
		send_byte(1'b1, 8'h00);
		send_frame(8'hFF, 8'hFF, 1, 1'b1);
		wait_idle();
		set_config(8'h00, 8'h00, 8'd2);
		send_byte(1'b1, 8'hFF);
		send_frame(8'h00, 8'h00, 2, 1'b0);
	endtask

	// Body limit: too long, exactly at the limit, and length shrunk mid-body
	task automatic test_long_body();
		wait_idle();
		set_config(8'h10, 8'h20, 8'd255);
		send_byte(1'b1, 8'h00);
		send_frame(8'h10, 8'h20, 251, 1'b0);
		wait_idle();
		set_config(8'h10, 8'h20, BODY_LIMIT);
		send_byte(1'b1, 8'h00);
		send_frame(8'h10, 8'h20, 250, 1'b0);
		wait_idle();
		set_config(8'h10, 8'h20, 8'd10);
		send_byte(1'b1, 8'h00);
		send_byte(1'b0, START_BYTE);
		send_byte(1'b0, 8'h10);
		send_byte(1'b0, 8'h20);
		repeat (5) send_byte(1'b0, 8'($urandom_range(255)));
		wait_idle();
		// Shrink the length below the bytes already taken: only the limit ends the body
		set_config(8'h10, 8'h20, 8'd3);
		repeat (246) send_byte(1'b0, 8'($urandom_range(255)));
	endtask

	// Hold the receiver off while the sender keeps going, so the block backs up
	task automatic test_backpressure();
		wait_idle();
		set_config(8'h21, 8'h42, 8'd6);
		send_idle_pct = 0;
		stall_pct = 0;
		hold_req = 200;
		repeat (8) begin
			send_byte(1'b1, 8'h00);
			send_frame(8'h21, 8'h42, 6, $urandom_range(3) == 0);
		end
	endtask

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(3))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	// Mostly well-formed frames with random content, plus broken frames and noise
	task automatic test_random_frames();
		int unsigned idle_mix[4] = '{0, 53, 0, 17};
		int unsigned stall_mix[4] = '{0, 0, 53, 17};
		int unsigned start;
		int unsigned k;
		logic [7:0]  len;
		logic [7:0]  nz;
		for (int m = 0; m < 4; m++) begin
			for (int rnd = 0; rnd < 5; rnd++) begin
				wait_idle();
				send_idle_pct = idle_mix[m];
				stall_pct = stall_mix[m];
				k = $urandom_range(99);
				if (k < 70)
					len = 8'($urandom_range(1, 8));
				else if (k < 85)
					len = 8'd0;
				else if (k < 96)
					len = 8'($urandom_range(9, 40));
				else
					len = 8'($urandom_range(250, 255));
				set_config(pick_byte(), pick_byte(), len);
				start = useful_items;
				while (useful_items - start < 20) begin
					k = $urandom_range(99);
					nz = 8'($urandom_range(1, 255));
					if (k < 70) begin
						if ($urandom_range(9) != 0)
							send_byte(1'b1, 8'($urandom_range(255)));
						repeat ($urandom_range(2)) send_byte(1'b0, noise_byte());
						send_frame(exp_cfg.device_class, exp_cfg.device_id,
							32'(exp_cfg.reply_length), $urandom_range(6) == 0);
						// trailing bytes fall into the ignoring phase
						repeat ($urandom_range(1)) send_byte(1'b0, 8'($urandom_range(255)));
					end else if (k < 80) begin
						send_byte(1'b1, 8'($urandom_range(255)));
						if ($urandom_range(1))
							send_frame(exp_cfg.device_class ^ nz, exp_cfg.device_id,
								32'(exp_cfg.reply_length), 1'b0);
						else
							send_frame(exp_cfg.device_class, exp_cfg.device_id ^ nz,
								32'(exp_cfg.reply_length), 1'b0);
					end else if (k < 88) begin
						// cut the frame short; a later new exchange abandons it
						send_byte(1'b1, 8'($urandom_range(255)));
						send_byte(1'b0, START_BYTE);
						send_byte(1'b0, exp_cfg.device_class);
						send_byte(1'b0, exp_cfg.device_id);
						repeat ($urandom_range(32'(exp_cfg.reply_length)))
							send_byte(1'b0, 8'($urandom_range(255)));
					end else if (k < 95) begin
						repeat ($urandom_range(1, 4))
							send_byte(1'b0, ($urandom_range(3) == 0) ? START_BYTE :
								8'($urandom_range(255)));
					end else
						send_byte(1'b1, 8'($urandom_range(255)));
				end
			end
		end
	endtask

	// Receiver: hold off on request, else stall at the current rate
	always @(posedge clk) begin
		if (hold_req != 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (hold_left != 0) begin
			hold_left--;
			result_ready <= 1'b0;
		end else
			result_ready <= ($urandom_range(99) >= stall_pct);
	end

	// Compare each accepted result with the oldest expectation
	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && result_valid && result_ready) begin
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("[%0t] result with nothing expected: %p", $realtime, result_data);
			end else begin
				want = expected_results.pop_front();
				if (result_data.body_valid !== want.body_valid ||
						result_data.body_byte !== want.body_byte ||
						result_data.body_index !== want.body_index ||
						result_data.answer_ready !== want.answer_ready ||
						result_data.checksum_error !== want.checksum_error ||
						result_data.phase !== want.phase) begin
					mismatches++;
					if (mismatches <= 10)
						$display("[%0t] mismatch: expected %p, got %p",
							$realtime, want, result_data);
				end
			end
		end
	end

	initial begin
		exp_cfg.device_class = RST_DEVICE_CLASS;
		exp_cfg.device_id = RST_DEVICE_ID;
		exp_cfg.reply_length = RST_REPLY_LENGTH;
		exp_phase = PH_IDLE;
		exp_hdr_second = 1'b0;
		exp_body_cnt = '0;
		exp_sum = '0;
		exp_ready = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_settings();
		test_header_mismatch();
		test_checksum();
		test_long_body();
		test_backpressure();
		test_random_frames();
		wait_idle();
		repeat (8) @(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("** serial_reply_frame_parser_unit: PASSED **");
		else
			$display("** serial_reply_frame_parser_unit: FAILED **");
		$finish;
	end

	// Watchdog: far beyond the slowest correct run
	initial begin
		#5_000_000;
		$display("** serial_reply_frame_parser_unit: FAILED **");
		$finish;
	end

endmodule

[sim.f]
+incdir+rtl
rtl/srfp_pkg.sv
rtl/srfp_cfg.sv
rtl/srfp_core.sv
rtl/serial_reply_frame_parser_unit.sv
tb/tb.sv
